// ----- hdl/button_debounce_hold_repeat_assert.svh -----
// Assertion macros shared by the button debounce and hold-repeat RTL.
`ifndef BUTTON_DEBOUNCE_HOLD_REPEAT_ASSERT_SVH
`define BUTTON_DEBOUNCE_HOLD_REPEAT_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define BDHR_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Check that a condition implies another in the following cycle.
`define BDHR_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- hdl/bdhr_pkg.sv -----
// Shared types and constants for the button debounce and hold-repeat block.
`timescale 1ns / 1ps
`default_nettype none

package bdhr_pkg;

    localparam int TICK_W      = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICKS     = 2'd1;

    localparam logic [TICK_W-1:0] DEBOUNCE_TICKS_RESET = 16'd10;
    localparam logic [TICK_W-1:0] HOLD_TICKS_RESET     = 16'd1000;

    // Reload values handed to every button cell.
    typedef struct packed {
        logic [TICK_W-1:0] debounce_ticks;
        logic [TICK_W-1:0] hold_ticks;
    } bdhr_cfg_t;

    // Pulses produced by one button cell for the current tick.
    typedef struct packed {
        logic press;
        logic hold;
    } bdhr_pulse_t;

endpackage

`default_nettype wire

// ----- hdl/bdhr_button.sv -----
// Per-button debounce sampler, hold timer and mode machine.
`timescale 1ns / 1ps
`default_nettype none

`include "button_debounce_hold_repeat_assert.svh"

module bdhr_button
    import bdhr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step_en,
    input  wire logic        raw_level,
    input  wire bdhr_cfg_t   cfg,
    output bdhr_pulse_t      pulse
);

    typedef enum logic [2:0] {
        MODE_INIT     = 3'd0,
        MODE_RELEASE  = 3'd1,
        MODE_PRESS    = 3'd2,
        MODE_PREHOLD  = 3'd3,
        MODE_HOLD     = 3'd4,
        MODE_POSTHOLD = 3'd5
    } mode_t;

    mode_t             mode_reg;
    mode_t             mode_next;
    logic [2:0]        hist_reg;
    logic [2:0]        hist_next;
    logic [TICK_W-1:0] dcnt_reg;
    logic [TICK_W-1:0] dcnt_next;
    logic [TICK_W-1:0] hcnt_reg;
    logic [TICK_W-1:0] hcnt_next;

    logic [TICK_W-1:0] dcnt_step;
    logic [TICK_W-1:0] hcnt_step;
    logic [2:0]        hist_sampled;
    logic              stable_press;
    logic              stable_release;

    // Sample when the debounce countdown has run out.
    always_comb
    begin
        if (dcnt_reg == '0)
        begin
            hist_sampled = {hist_reg[1:0], raw_level};
        end
        else
        begin
            hist_sampled = hist_reg;
        end
        stable_press   = (hist_sampled == 3'b000);
        stable_release = (hist_sampled == 3'b111);
    end

    always_comb
    begin
        mode_next = mode_reg;
        hist_next = hist_reg;
        dcnt_step = dcnt_reg;
        hcnt_step = hcnt_reg;
        case (mode_reg)
            MODE_INIT:
            begin
                dcnt_step = cfg.debounce_ticks;
                mode_next = MODE_RELEASE;
            end
            MODE_RELEASE:
            begin
                hist_next = hist_sampled;
                if (dcnt_reg == '0)
                begin
                    dcnt_step = cfg.debounce_ticks;
                end
                if (stable_press)
                begin
                    mode_next = MODE_PRESS;
                end
            end
            MODE_PRESS:
            begin
                hcnt_step = cfg.hold_ticks;
                mode_next = MODE_PREHOLD;
            end
            MODE_PREHOLD, MODE_POSTHOLD:
            begin
                hist_next = hist_sampled;
                if (dcnt_reg == '0)
                begin
                    dcnt_step = cfg.debounce_ticks;
                end
                if (stable_release)
                begin
                    mode_next = MODE_RELEASE;
                end
                else if (stable_press && (hcnt_reg == '0))
                begin
                    hcnt_step = cfg.hold_ticks;
                    mode_next = MODE_HOLD;
                end
            end
            MODE_HOLD:
            begin
                mode_next = MODE_POSTHOLD;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        // Count down every nonzero timer after the step, fresh reloads included.
        dcnt_next = (dcnt_step != '0) ? dcnt_step - TICK_W'(1) : dcnt_step;
        hcnt_next = (hcnt_step != '0) ? hcnt_step - TICK_W'(1) : hcnt_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_INIT;
            hist_reg <= 3'b111;
            dcnt_reg <= '0;
            hcnt_reg <= '0;
        end
        else if (step_en)
        begin
            mode_reg <= mode_next;
            hist_reg <= hist_next;
            dcnt_reg <= dcnt_next;
            hcnt_reg <= hcnt_next;
        end
    end

    assign pulse.press = (mode_next == MODE_PRESS);
    assign pulse.hold  = (mode_next == MODE_HOLD);

    `BDHR_ASSERT_NEXT(a_press_to_prehold, step_en && (mode_reg == MODE_PRESS),
        mode_reg == MODE_PREHOLD, "press mode did not advance to prehold")
    `BDHR_ASSERT_SAME(a_press_history, mode_reg == MODE_PRESS, hist_reg == 3'b000,
        "press mode without a stable press history")
    `BDHR_ASSERT_SAME(a_hold_history, mode_reg == MODE_HOLD, hist_reg == 3'b000,
        "hold mode without a stable press history")

endmodule

`default_nettype wire

// ----- hdl/button_debounce_hold_repeat.sv -----
// Top level of the button debounce and hold-repeat block.
`timescale 1ns / 1ps
`default_nettype none

`include "button_debounce_hold_repeat_assert.svh"

// Each input word is one tick carrying the raw active-low pin levels of BUTTONS
// buttons (bit i low means button i is pressed). Each button samples its pin every
// debounce_ticks ticks into a three-sample history, and a per-button machine
// raises press_pulses[i] for one word on a debounced press, then hold_pulses[i]
// for one word every hold_ticks ticks while the press stays stable, and goes back
// to idle on a debounced release. One result word comes out for every input word.
// The block takes one word per clock while the output is not stalled: a word is
// held in the input register, stepped through the button cells in one pass, and
// the pulses land in the output register. The input register keeps accepting while
// a finished result waits in the output register; stall on the input only rises
// when both registers are full and the output is stalled. Configuration writes
// (index 0 debounce_ticks, index 1 hold_ticks, 16 bits each, others dropped) are
// always ready and should be made only while no word is in flight.
module button_debounce_hold_repeat
    import bdhr_pkg::*;
#(
    parameter int BUTTONS = 3
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [BUTTONS-1:0]     raw_levels,

    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [BUTTONS-1:0]          press_pulses,
    output logic [BUTTONS-1:0]          hold_pulses,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [TICK_W-1:0]      cfg_data
);

    bdhr_cfg_t          cfg_reg;
    logic               in_valid_reg;
    logic [BUTTONS-1:0] raw_reg;
    logic               out_valid_reg;
    logic [BUTTONS-1:0] press_reg;
    logic [BUTTONS-1:0] hold_reg;

    logic               advance;
    logic               in_take;
    bdhr_pulse_t        pulses [BUTTONS];
    logic [BUTTONS-1:0] press_next;
    logic [BUTTONS-1:0] hold_next;

    // Step the cells when the held word can move into the output register.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign cfg_ready = 1'b1;

    // Register writes; drop anything beyond the two defined indexes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks <= DEBOUNCE_TICKS_RESET;
            cfg_reg.hold_ticks     <= HOLD_TICKS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DEBOUNCE_TICKS: cfg_reg.debounce_ticks <= cfg_data;
                REG_HOLD_TICKS:     cfg_reg.hold_ticks     <= cfg_data;
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Input register: hold the tick until the cells consume it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            raw_reg <= raw_levels;
        end
    end

    genvar b;
    generate
        for (b = 0; b < BUTTONS; b++)
        begin : g_button
            bdhr_button u_button (
                .clk       (clk),
                .rst_n     (rst_n),
                .step_en   (advance),
                .raw_level (raw_reg[b]),
                .cfg       (cfg_reg),
                .pulse     (pulses[b])
            );
            assign press_next[b] = pulses[b].press;
            assign hold_next[b]  = pulses[b].hold;
        end
    endgenerate

    // Output register: hold the result word until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            press_reg <= press_next;
            hold_reg  <= hold_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign press_pulses = press_reg;
    assign hold_pulses  = hold_reg;

    `BDHR_ASSERT_SAME(a_stall_needs_word, in_stall, in_valid_reg && out_valid_reg,
        "input stalled without both registers full")
    `BDHR_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_reg,
        "stepped word did not reach the output register")

endmodule

`default_nettype wire
